// ===== rtl/exm_pkg.sv =====
// Package for the Euler X-Y-Z model matrix block.
// Shared types, pipeline depths and the Q30 product and coefficient helpers.
// No dependencies.
`default_nettype none

package exm_pkg;

    localparam int COEF_FRAC_BITS = 14;

    typedef logic signed [31:0] q30_t;

    localparam q30_t Q30_ONE = 32'sh4000_0000;

    // angle reduction and degree to radian scaling
    localparam logic [17:0] ANG_OFFSET   = 18'd46080;  // two full turns
    localparam logic [14:0] FULL_TURN    = 15'd23040;
    localparam logic [14:0] QUARTER_TURN = 15'd5760;
    localparam logic [14:0] HALF_TURN    = 15'd11520;
    localparam logic [14:0] THREE_QUARTER_TURN = 15'd17280;
    localparam logic [31:0] RAD_INT      = 32'd292817;  // floor(pi/2 Q30 / 5760)
    localparam logic [11:0] RAD_REM      = 12'd3793;    // remainder of the above
    localparam logic [24:0] RAD_HALF     = 25'd2880;
    localparam int          RAD_SHIFT    = 38;
    localparam logic [25:0] RAD_MAGIC    =
        26'(((64'd1 << RAD_SHIFT) + 64'd5759) / 64'd5760);

    localparam int SC_TERMS = 8;
    localparam int SC_LAT   = 5 + 2 * SC_TERMS + 1;
    localparam int MX_LAT   = 3;
    localparam int PIPE_LAT = SC_LAT + MX_LAT;

    localparam int CF_SHIFT = 30 - COEF_FRAC_BITS;
    localparam logic [33:0] CF_HALF = (34'd1 << CF_SHIFT) >> 1;
    localparam logic [33:0] CF_LIM  = 34'd1 << COEF_FRAC_BITS;

    typedef struct packed {
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } xform_t;

    typedef struct packed {
        logic signed [15:0] rot_00;
        logic signed [15:0] rot_01;
        logic signed [15:0] rot_02;
        logic signed [15:0] rot_10;
        logic signed [15:0] rot_11;
        logic signed [15:0] rot_12;
        logic signed [15:0] rot_20;
        logic signed [15:0] rot_21;
        logic signed [15:0] rot_22;
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
    } matrix_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } pos_t;

    // Q30 product, magnitude rounded half away from zero
    function automatic q30_t mul30(input q30_t a, input q30_t b);
        logic [30:0] ma;
        logic [30:0] mb;
        logic [61:0] p;
        logic [31:0] r;
        ma = a[31] ? 31'(-a) : 31'(a);
        mb = b[31] ? 31'(-b) : 31'(b);
        p  = 62'(ma) * 62'(mb) + (62'd1 << 29);
        r  = p[61:30];
        return (a[31] != b[31]) ? -$signed(r) : $signed(r);
    endfunction

    // Q30 to coefficient format: round, saturate, keep low 16 bits
    function automatic logic [15:0] to_coef(input logic signed [32:0] v);
        logic [32:0] m;
        logic [33:0] r;
        logic [33:0] s;
        m = v[32] ? 33'(-v) : 33'(v);
        r = ({1'b0, m} + CF_HALF) >> CF_SHIFT;
        if (r > CF_LIM)
        begin
            r = CF_LIM;
        end
        s = v[32] ? -r : r;
        return s[15:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/euler_xyz_model_matrix.sv =====
// Top level: Euler X-Y-Z angles and position in, 3x4 model matrix out.
// Depends on exm_pkg and exm_sincos.
//
//   channel  | valid          | stall          | payload
//   ---------+----------------+----------------+---------------------
//   input    | xform_valid    | xform_stall    | xform  (xform_t)
//   output   | matrix_valid   | matrix_stall   | matrix (matrix_t)
//
// One transaction per cycle unless the output stalls; the sine/cosine
// series pipeline feeds the matrix products, sums and rounding.
// Reset clears only the valid bits of the stages.
// A stalled, full output register freezes the whole pipeline and holds
// xform_stall high; otherwise a new transaction enters every cycle.
`default_nettype none

module euler_xyz_model_matrix
    import exm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    xform_valid,
    output logic         xform_stall,
    input  wire xform_t  xform,
    output logic         matrix_valid,
    input  wire logic    matrix_stall,
    output matrix_t      matrix
);

    logic en;
    logic [PIPE_LAT-1:0] vld_reg;

    assign en          = !(vld_reg[PIPE_LAT-1] && matrix_stall);
    assign xform_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], xform_valid};
        end
    end

    // position rides alongside
    pos_t pos_reg [PIPE_LAT-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg[0] <= '{x: xform.pos_x, y: xform.pos_y, z: xform.pos_z};
            for (int i = 1; i < PIPE_LAT - 1; i++)
            begin
                pos_reg[i] <= pos_reg[i-1];
            end
        end
    end

    q30_t sx, cx, sy, cy, sz, cz;

    exm_sincos u_sc_x (.clk(clk), .en(en), .angle(xform.angle_x), .sin_q(sx), .cos_q(cx));
    exm_sincos u_sc_y (.clk(clk), .en(en), .angle(xform.angle_y), .sin_q(sy), .cos_q(cy));
    exm_sincos u_sc_z (.clk(clk), .en(en), .angle(xform.angle_z), .sin_q(sz), .cos_q(cz));

    // first products
    q30_t sxsy_reg, cxsy_reg, cycz_reg, cysz_reg, sxcy_reg, cxcy_reg;
    q30_t cxsz_reg, cxcz_reg, sxsz_reg, sxcz_reg, sy1_reg, cz1_reg, sz1_reg;
    // second products
    q30_t p10_reg, p11_reg, p20_reg, p21_reg;
    q30_t cycz2_reg, cysz2_reg, sxcy2_reg, cxcy2_reg;
    q30_t cxsz2_reg, cxcz2_reg, sxsz2_reg, sxcz2_reg, sy2_reg;
    matrix_t out_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sxsy_reg <= mul30(sx, sy);
            cxsy_reg <= mul30(cx, sy);
            cycz_reg <= mul30(cy, cz);
            cysz_reg <= mul30(cy, sz);
            sxcy_reg <= mul30(sx, cy);
            cxcy_reg <= mul30(cx, cy);
            cxsz_reg <= mul30(cx, sz);
            cxcz_reg <= mul30(cx, cz);
            sxsz_reg <= mul30(sx, sz);
            sxcz_reg <= mul30(sx, cz);
            sy1_reg  <= sy;
            cz1_reg  <= cz;
            sz1_reg  <= sz;

            p10_reg   <= mul30(sxsy_reg, cz1_reg);
            p11_reg   <= mul30(sxsy_reg, sz1_reg);
            p20_reg   <= mul30(cxsy_reg, cz1_reg);
            p21_reg   <= mul30(cxsy_reg, sz1_reg);
            cycz2_reg <= cycz_reg;
            cysz2_reg <= cysz_reg;
            sxcy2_reg <= sxcy_reg;
            cxcy2_reg <= cxcy_reg;
            cxsz2_reg <= cxsz_reg;
            cxcz2_reg <= cxcz_reg;
            sxsz2_reg <= sxsz_reg;
            sxcz2_reg <= sxcz_reg;
            sy2_reg   <= sy1_reg;

            out_reg.rot_00  <= to_coef(33'(cycz2_reg));
            out_reg.rot_01  <= to_coef(-33'(cysz2_reg));
            out_reg.rot_02  <= to_coef(33'(sy2_reg));
            out_reg.rot_10  <= to_coef(33'(p10_reg) + 33'(cxsz2_reg));
            out_reg.rot_11  <= to_coef(33'(cxcz2_reg) - 33'(p11_reg));
            out_reg.rot_12  <= to_coef(-33'(sxcy2_reg));
            out_reg.rot_20  <= to_coef(33'(sxsz2_reg) - 33'(p20_reg));
            out_reg.rot_21  <= to_coef(33'(p21_reg) + 33'(sxcz2_reg));
            out_reg.rot_22  <= to_coef(33'(cxcy2_reg));
            out_reg.trans_x <= pos_reg[PIPE_LAT-2].x;
            out_reg.trans_y <= pos_reg[PIPE_LAT-2].y;
            out_reg.trans_z <= pos_reg[PIPE_LAT-2].z;
        end
    end

    assign matrix       = out_reg;
    assign matrix_valid = vld_reg[PIPE_LAT-1];

endmodule

`default_nettype wire

// ===== rtl/exm_sincos.sv =====
// Pipelined sine and cosine of one angle (Q10.6 degrees) in Q30.
// Fold to a quarter turn, scale to radians, Taylor series one term pair per two stages.
// Depends on exm_pkg.
`default_nettype none

module exm_sincos
    import exm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [15:0] angle,
    output q30_t                    sin_q,
    output q30_t                    cos_q
);

    typedef struct packed {
        logic [31:0]        ts;
        logic [31:0]        tc;
        logic [31:0]        th2;
        logic signed [35:0] ssum;
        logic signed [35:0] csum;
        logic               neg;
        logic               flip;
    } sc_iter_t;

    function automatic q30_t clamp_q30(input logic signed [35:0] v);
        q30_t r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > 36'sh0_4000_0000)
        begin
            r = Q30_ONE;
        end
        else
        begin
            r = q30_t'(v[31:0]);
        end
        return r;
    endfunction

    // stage 1: reduce and fold
    logic [17:0]        a_off;
    logic [14:0]        m;
    logic signed [15:0] d;
    logic               flip1_next;
    logic [12:0]        mag1_reg;
    logic               neg1_reg;
    logic               flip1_reg;

    always_comb
    begin
        a_off = {{2{angle[15]}}, angle} + ANG_OFFSET;
        if (a_off >= 18'(3 * FULL_TURN))
        begin
            m = 15'(a_off - 18'(3 * FULL_TURN));
        end
        else if (a_off >= 18'(2 * FULL_TURN))
        begin
            m = 15'(a_off - 18'(2 * FULL_TURN));
        end
        else if (a_off >= 18'(FULL_TURN))
        begin
            m = 15'(a_off - 18'(FULL_TURN));
        end
        else
        begin
            m = a_off[14:0];
        end
        flip1_next = 1'b0;
        if (m <= QUARTER_TURN)
        begin
            d = $signed({1'b0, m});
        end
        else if (m <= THREE_QUARTER_TURN)
        begin
            d = $signed({1'b0, m}) - $signed({1'b0, HALF_TURN});
            flip1_next = 1'b1;
        end
        else
        begin
            d = $signed({1'b0, m}) - $signed({1'b0, FULL_TURN});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg  <= d[15];
            mag1_reg  <= d[15] ? 13'(-d) : 13'(d);
            flip1_reg <= flip1_next;
        end
    end

    // stages 2-4: theta = round(mag * (pi/2 Q30) / 5760)
    logic [31:0] hi2_reg;
    logic [24:0] num2_reg;
    logic        neg2_reg;
    logic        flip2_reg;
    logic [31:0] hi3_reg;
    logic [11:0] q3_reg;
    logic        neg3_reg;
    logic        flip3_reg;
    logic [31:0] theta4_reg;
    logic        neg4_reg;
    logic        flip4_reg;
    logic [50:0] q3_prod;
    logic [63:0] sq5;
    sc_iter_t    pre_reg;

    assign q3_prod = 51'(num2_reg) * 51'(RAD_MAGIC);
    assign sq5     = 64'(theta4_reg) * 64'(theta4_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hi2_reg    <= 32'(mag1_reg) * RAD_INT;
            num2_reg   <= 25'(mag1_reg) * 25'(RAD_REM) + RAD_HALF;
            neg2_reg   <= neg1_reg;
            flip2_reg  <= flip1_reg;
            hi3_reg    <= hi2_reg;
            q3_reg     <= 12'(q3_prod >> RAD_SHIFT);
            neg3_reg   <= neg2_reg;
            flip3_reg  <= flip2_reg;
            theta4_reg <= hi3_reg + 32'(q3_reg);
            neg4_reg   <= neg3_reg;
            flip4_reg  <= flip3_reg;
            pre_reg.ts   <= theta4_reg;
            pre_reg.tc   <= 32'(Q30_ONE);
            pre_reg.th2  <= sq5[61:30];
            pre_reg.ssum <= 36'(theta4_reg);
            pre_reg.csum <= 36'(Q30_ONE);
            pre_reg.neg  <= neg4_reg;
            pre_reg.flip <= flip4_reg;
        end
    end

    // series terms: stage A multiplies by theta^2, stage B divides by n(n-1)
    sc_iter_t a_reg [SC_TERMS];
    sc_iter_t b_reg [SC_TERMS];

    for (genvar k = 0; k < SC_TERMS; k++)
    begin : g_term
        localparam int CS = (2 * k + 3) * (2 * k + 2);
        localparam int CC = (2 * k + 2) * (2 * k + 1);
        localparam int SS = 32 + $clog2(CS);
        localparam int SC = 32 + $clog2(CC);
        localparam logic [32:0] MS =
            33'(((64'd1 << SS) + 64'(CS) - 64'd1) / 64'(CS));
        localparam logic [32:0] MC =
            33'(((64'd1 << SC) + 64'(CC) - 64'd1) / 64'(CC));

        sc_iter_t    src;
        sc_iter_t    a_next;
        sc_iter_t    b_next;
        logic [63:0] ps;
        logic [63:0] pc;
        logic [64:0] qs;
        logic [64:0] qc;

        if (k == 0)
        begin : g_first
            assign src = pre_reg;
        end
        else
        begin : g_chain
            assign src = b_reg[k-1];
        end

        assign ps = 64'(src.ts) * 64'(src.th2);
        assign pc = 64'(src.tc) * 64'(src.th2);
        assign qs = 65'(a_reg[k].ts) * 65'(MS);
        assign qc = 65'(a_reg[k].tc) * 65'(MC);

        always_comb
        begin
            a_next = src;
            // sine has one term fewer than cosine
            if (k < SC_TERMS - 1)
            begin
                a_next.ts = ps[61:30];
            end
            a_next.tc = pc[61:30];
            if (k % 2 == 1)
            begin
                a_next.ssum = src.ssum - $signed(36'(src.ts));
                a_next.csum = src.csum - $signed(36'(src.tc));
            end
            else if (k > 0)
            begin
                a_next.ssum = src.ssum + $signed(36'(src.ts));
                a_next.csum = src.csum + $signed(36'(src.tc));
            end
            b_next = a_reg[k];
            if (k < SC_TERMS - 1)
            begin
                b_next.ts = 32'(qs >> SS);
            end
            b_next.tc = 32'(qc >> SC);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_reg[k] <= a_next;
                b_reg[k] <= b_next;
            end
        end
    end

    // last stage: final cosine term, clamp, signs
    logic signed [35:0] csum_fin;
    q30_t               s_mag;
    q30_t               c_mag;
    q30_t               s_fin;
    q30_t               c_fin;
    q30_t               sin_reg;
    q30_t               cos_reg;

    always_comb
    begin
        csum_fin = b_reg[SC_TERMS-1].csum + $signed(36'(b_reg[SC_TERMS-1].tc));
        s_mag    = clamp_q30(b_reg[SC_TERMS-1].ssum);
        c_mag    = clamp_q30(csum_fin);
        s_fin    = (b_reg[SC_TERMS-1].neg ^ b_reg[SC_TERMS-1].flip) ? -s_mag : s_mag;
        c_fin    = b_reg[SC_TERMS-1].flip ? -c_mag : c_mag;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= s_fin;
            cos_reg <= c_fin;
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

`default_nettype wire
